[hw/rtl/i2cms_pkg.sv]
`timescale 1ns / 1ps

package i2cms_pkg;

  // Command codes
  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_RACK  = 3'd5
  } op_t;

  localparam int unsigned STEP_W = 6;

  // Sequencer state
  typedef struct packed {
    logic              running;
    op_t               cmd;
    logic [STEP_W-1:0] step;
    logic [1:0]        phase;   // position inside one bit slot
    logic [2:0]        bitn;    // bit slot, MSB first
    logic [7:0]        shift_out;
    logic [7:0]        shift_in;
    logic              ack_hold;
    logic              scl;
    logic              sda;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{
    running:   1'b0,
    cmd:       OP_START,
    step:      '0,
    phase:     2'd0,
    bitn:      3'd0,
    shift_out: 8'h00,
    shift_in:  8'h00,
    ack_hold:  1'b1,
    scl:       1'b1,
    sda:       1'b1
  };

  // One result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_seen;
  } seq_result_t;

  // Index of the final step of each command
  function automatic logic [STEP_W-1:0] last_step(input op_t cmd);
    logic [STEP_W-1:0] r;
    r = 6'd3;
    unique case (cmd)
      OP_START: r = 6'd3;
      OP_STOP:  r = 6'd2;
      OP_WRITE: r = 6'd23;
      OP_READ:  r = 6'd32;
      OP_SACK:  r = 6'd2;
      OP_RACK:  r = 6'd3;
      default:  r = 6'd3;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/i2cms_core.sv]
`timescale 1ns / 1ps

// Next-state and result logic for one line step.
module i2cms_core (
  input  i2cms_pkg::seq_state_t  cur,
  input  logic                   cmd_valid,
  input  logic [2:0]             opcode,
  input  logic [7:0]             tx_byte,
  input  logic                   ack_level,
  input  logic                   sda_in,
  output i2cms_pkg::seq_state_t  nxt,
  output i2cms_pkg::seq_result_t res
);

  i2cms_pkg::seq_state_t st;
  i2cms_pkg::seq_state_t nx;
  logic                  start;
  logic                  busy;
  logic                  done;

  always_comb begin
    st    = cur;
    busy  = 1'b0;
    done  = 1'b0;
    start = !cur.running && cmd_valid &&
            (opcode <= 3'(i2cms_pkg::OP_RACK));

    // Launch a new command from idle
    if (start) begin
      st.running = 1'b1;
      st.cmd     = i2cms_pkg::op_t'(opcode);
      st.step    = '0;
      st.phase   = 2'd0;
      st.bitn    = 3'd0;
      if (st.cmd == i2cms_pkg::OP_WRITE) st.shift_out = tx_byte;
      if (st.cmd == i2cms_pkg::OP_READ)  st.shift_in  = 8'h00;
      if (st.cmd == i2cms_pkg::OP_SACK)  st.sda       = ack_level;
    end

    nx = st;

    if (st.running) begin
      busy = 1'b1;

      // Pin action for this step
      unique case (st.cmd)
        i2cms_pkg::OP_START: begin
          unique case (st.step)
            6'd0:    nx.sda = 1'b1;
            6'd1:    nx.scl = 1'b1;
            6'd2:    nx.sda = 1'b0;
            default: nx.scl = 1'b0;
          endcase
        end
        i2cms_pkg::OP_STOP: begin
          unique case (st.step)
            6'd0:    nx.sda = 1'b0;
            6'd1:    nx.scl = 1'b1;
            default: nx.sda = 1'b1;
          endcase
        end
        i2cms_pkg::OP_WRITE: begin
          unique case (st.phase)
            2'd0:    nx.sda = st.shift_out[3'd7 - st.bitn];
            2'd1:    nx.scl = 1'b1;
            default: nx.scl = 1'b0;
          endcase
        end
        i2cms_pkg::OP_READ: begin
          if (st.step == '0) begin
            nx.sda = 1'b1;
          end else begin
            unique case (st.phase)
              2'd0: nx.scl = 1'b0;
              2'd1: nx.scl = 1'b1;
              2'd2: begin
                if (sda_in) nx.shift_in[3'd7 - st.bitn] = 1'b1;
              end
              default: nx.scl = 1'b0;
            endcase
          end
        end
        i2cms_pkg::OP_SACK: begin
          // step 0 drove SDA at launch
          if (st.step == 6'd1)      nx.scl = 1'b1;
          else if (st.step == 6'd2) nx.scl = 1'b0;
        end
        i2cms_pkg::OP_RACK: begin
          unique case (st.step)
            6'd0:    nx.sda = 1'b1;
            6'd1:    nx.scl = 1'b1;
            6'd2:    nx.ack_hold = sda_in;
            default: nx.scl = 1'b0;
          endcase
        end
        default: ;
      endcase

      // Step bookkeeping
      if (st.step == i2cms_pkg::last_step(st.cmd)) begin
        done       = 1'b1;
        nx.running = 1'b0;
        nx.step    = '0;
      end else begin
        nx.step = st.step + 6'd1;
        if (st.cmd == i2cms_pkg::OP_WRITE) begin
          if (st.phase == 2'd2) begin
            nx.phase = 2'd0;
            nx.bitn  = st.bitn + 3'd1;
          end else begin
            nx.phase = st.phase + 2'd1;
          end
        end else if (st.cmd == i2cms_pkg::OP_READ && st.step != '0) begin
          if (st.phase == 2'd3) begin
            nx.phase = 2'd0;
            nx.bitn  = st.bitn + 3'd1;
          end else begin
            nx.phase = st.phase + 2'd1;
          end
        end
      end
    end
  end

  assign nxt = nx;

  assign res = '{
    scl_level: nx.scl,
    sda_level: nx.sda,
    busy_res:  busy,
    done_res:  done,
    rx_data:   nx.shift_in,
    ack_seen:  nx.ack_hold
  };

endmodule

[hw/rtl/i2c_master_line_sequencer.sv]
`timescale 1ns / 1ps
// A result beat is registered and appears in the cycle after its input beat is accepted.
// One input beat per cycle unless stalled; each is one line step and gives one result beat.
// The output register holds a stalled result; input is taken whenever it is free or draining.
// Reset (synchronous, rst_n low): idle, both lines released, ack seen = 1, no result pending.

module i2c_master_line_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], ack_level[8], sda_in[9], zero[15:10]
  input  logic [3:0]  in_tuser,   // cmd_valid[0], opcode[3:1]
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // scl_level[0], sda_level[1], busy_res[2],
                                  // rx_data[10:3], ack_seen[11], zero[15:12]
  output logic        out_tlast   // done_res
);

  i2cms_pkg::seq_state_t  st_r, st_nxt;
  i2cms_pkg::seq_result_t res_r, res_nxt;
  logic                   out_valid_r;
  logic                   in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Step logic
  i2cms_core u_core (
    .cur       (st_r),
    .cmd_valid (in_tuser[0]),
    .opcode    (in_tuser[3:1]),
    .tx_byte   (in_tdata[7:0]),
    .ack_level (in_tdata[8]),
    .sda_in    (in_tdata[9]),
    .nxt       (st_nxt),
    .res       (res_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= i2cms_pkg::SEQ_RESET;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.done_res;
  assign out_tdata  = {4'b0000, res_r.ack_seen, res_r.rx_data, res_r.busy_res,
                       res_r.sda_level, res_r.scl_level};

endmodule

[hw/rtl/i2cms_checker.sv]
`timescale 1ns / 1ps

// Port-level checks for the line sequencer.
module i2cms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid after reset");

  // Every accepted input beat gives a result beat next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat produced no result");

  // Input side never blocks while the output register is empty
  a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A final step is always a busy step
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2])
    else $error("done without busy");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind i2c_master_line_sequencer i2cms_checker u_i2cms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
